// ===== sv/stream_find_replace_top_defines.svh =====
// Assertion macros shared by the stream find-and-replace modules.
// The enclosing module must provide i_clk and i_rst_n.
`ifndef STREAM_FIND_REPLACE_TOP_DEFINES_SVH
`define STREAM_FIND_REPLACE_TOP_DEFINES_SVH

`ifndef SYNTH

`define SFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sfr: assertion failed");

`define SFR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfr: implication failed");

`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfr: next-cycle check failed");

`else

`define SFR_ASSERT(lbl, prop)
`define SFR_ASSERT_IMPL(lbl, ante, cons)
`define SFR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/sfr_pkg.sv =====
package sfr_pkg;

    // Bytes held by one pair of 64-bit pattern or replacement registers.
    localparam int REG_BYTES  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REP_HI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN = 3'd5;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REPL,
        S_FLUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit_held;
        logic emit_repl;
        logic repl_start;
        logic clear_count;
        logic final_push;
        logic bare_push;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic prefix_ok;
        logic count_eq_plen;
        logic repl_done;
        logic eos;
        logic pend_v;
        logic out_free;
        logic gen_ok;
    } t_status;

endpackage

// ===== sv/sfr_datapath.sv =====
`include "stream_find_replace_top_defines.svh"

module sfr_datapath #(
    parameter int HELD_DEPTH = 16,
    parameter int REPL_LIM   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_end_of_stream,
    input  logic                            i_stall,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  sfr_pkg::t_cmd                   i_cmd,
    output sfr_pkg::t_status                o_status,
    output logic                            o_valid,
    output logic [7:0]                      o_out_byte,
    output logic                            o_byte_valid,
    output logic                            o_run_last,
    output logic                            o_stream_end
);
    import sfr_pkg::*;

    localparam int CNT_W  = $clog2(HELD_DEPTH + 1);
    localparam int HIDX_W = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int RIDX_W = $clog2(REPL_LIM + 2);

    logic [CFG_DATA_W-1:0]   r_pat_lo;
    logic [CFG_DATA_W-1:0]   r_pat_hi;
    logic [CFG_DATA_W-1:0]   r_rep_lo;
    logic [CFG_DATA_W-1:0]   r_rep_hi;
    logic [LEN_W-1:0]        r_pat_len;
    logic [LEN_W-1:0]        r_rep_len;

    t_byte                   r_held [HELD_DEPTH];
    logic [CNT_W-1:0]        r_count;
    logic [RIDX_W-1:0]       r_ridx;
    logic                    r_eos;

    logic                    r_pend_v;
    t_byte                   r_pend_byte;
    logic                    r_out_v;
    t_byte                   r_out_byte;
    logic                    r_out_bv;
    logic                    r_out_last;
    logic                    r_out_end;

    logic [2*CFG_DATA_W-1:0] pat_vec;
    logic [2*CFG_DATA_W-1:0] rep_vec;
    logic [LEN_W-1:0]        plen;
    logic [LEN_W-1:0]        rlen;
    logic [LEN_W-1:0]        ridx_ext;
    logic                    prefix_ok;
    t_byte                   rep_byte;
    t_byte                   new_byte;
    logic                    gen;
    logic                    out_free;
    logic                    out_taken;
    logic                    push_out;

    assign pat_vec = {r_pat_hi, r_pat_lo};
    assign rep_vec = {r_rep_hi, r_rep_lo};

    // Effective lengths: a zero pattern length counts as one, both saturate.
    always_comb begin
        plen = r_pat_len;
        if (plen == '0) begin
            plen = LEN_W'(1);
        end
        if (plen > LEN_W'(HELD_DEPTH)) begin
            plen = LEN_W'(HELD_DEPTH);
        end
        rlen = r_rep_len;
        if (rlen > LEN_W'(REPL_LIM)) begin
            rlen = LEN_W'(REPL_LIM);
        end
    end

    always_comb begin
        prefix_ok = 1'b1;
        for (int i = 0; i < HELD_DEPTH; i++) begin
            if ((CNT_W'(i) < r_count) && (r_held[i] != pat_vec[i*8 +: 8])) begin
                prefix_ok = 1'b0;
            end
        end
    end

    assign ridx_ext  = LEN_W'(r_ridx);
    assign rep_byte  = rep_vec[ridx_ext[3:0]*8 +: 8];
    assign new_byte  = i_cmd.emit_held ? r_held[0] : rep_byte;
    assign gen       = i_cmd.emit_held || i_cmd.emit_repl;
    assign out_free  = !r_out_v || !i_stall;
    assign out_taken = r_out_v && !i_stall;
    assign push_out  = (gen && r_pend_v) || i_cmd.final_push || i_cmd.bare_push;

    assign o_status.count_zero    = (r_count == '0);
    assign o_status.prefix_ok     = prefix_ok;
    assign o_status.count_eq_plen = (LEN_W'(r_count) == plen);
    assign o_status.repl_done     = (ridx_ext == rlen);
    assign o_status.eos           = r_eos;
    assign o_status.pend_v        = r_pend_v;
    assign o_status.out_free      = out_free;
    assign o_status.gen_ok        = !r_pend_v || out_free;

    // Pattern writes are dropped while a prefix is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PAT_LO: begin
                    if (r_count == '0) r_pat_lo <= i_cfg_data;
                end
                REG_PAT_HI: begin
                    if (r_count == '0) r_pat_hi <= i_cfg_data;
                end
                REG_PAT_LEN: begin
                    if (r_count == '0) r_pat_len <= i_cfg_data[LEN_W-1:0];
                end
                REG_REP_LO: begin
                    r_rep_lo <= i_cfg_data;
                end
                REG_REP_HI: begin
                    r_rep_hi <= i_cfg_data;
                end
                REG_REP_LEN: begin
                    r_rep_len <= i_cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ridx   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.emit_held) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.clear_count) begin
                r_count <= '0;
            end

            if (i_cmd.repl_start) begin
                r_ridx <= '0;
            end else if (i_cmd.emit_repl) begin
                r_ridx <= r_ridx + RIDX_W'(1);
            end

            if (gen) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.final_push) begin
                r_pend_v <= 1'b0;
            end

            if (out_taken) begin
                r_out_v <= 1'b0;
            end
            if (push_out) begin
                r_out_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_held[r_count[HIDX_W-1:0]] <= i_in_byte;
            r_eos <= i_end_of_stream;
        end else if (i_cmd.emit_held) begin
            for (int i = 0; i < HELD_DEPTH - 1; i++) begin
                r_held[i] <= r_held[i+1];
            end
        end

        if (gen) begin
            r_pend_byte <= new_byte;
        end

        if (gen && r_pend_v) begin
            r_out_byte <= r_pend_byte;
            r_out_bv   <= 1'b1;
            r_out_last <= 1'b0;
            r_out_end  <= 1'b0;
        end else if (i_cmd.final_push) begin
            r_out_byte <= r_pend_byte;
            r_out_bv   <= 1'b1;
            r_out_last <= 1'b1;
            r_out_end  <= r_eos;
        end else if (i_cmd.bare_push) begin
            r_out_byte <= '0;
            r_out_bv   <= 1'b0;
            r_out_last <= 1'b1;
            r_out_end  <= 1'b1;
        end
    end

    assign o_valid      = r_out_v;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_out_bv;
    assign o_run_last   = r_out_last;
    assign o_stream_end = r_out_end;

    `SFR_ASSERT(a_count_bound, r_count <= CNT_W'(HELD_DEPTH))
    `SFR_ASSERT_IMPL(a_no_overwrite, gen && r_pend_v, out_free)
    `SFR_ASSERT_NEXT(a_final_marks_last, i_cmd.final_push, r_out_v && r_out_last && !r_pend_v)

endmodule

// ===== sv/sfr_ctrl.sv =====
`include "stream_find_replace_top_defines.svh"

module sfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sfr_pkg::t_status i_status,
    output logic             o_stall,
    output sfr_pkg::t_cmd    o_cmd
);
    import sfr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!i_status.count_zero && !i_status.prefix_ok) begin
                    n_state = S_SCAN;
                end else if (i_status.count_eq_plen) begin
                    n_state = S_REPL;
                end else if (i_status.eos) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REPL: begin
                if (i_status.repl_done) begin
                    n_state = i_status.eos ? S_FLUSH : S_DONE;
                end
            end
            S_FLUSH: begin
                if (i_status.count_zero) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.pend_v || i_status.eos) begin
                    if (i_status.out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_SCAN: begin
                if (!i_status.count_zero && !i_status.prefix_ok) begin
                    o_cmd.emit_held = i_status.gen_ok;
                end else if (i_status.count_eq_plen) begin
                    o_cmd.repl_start = 1'b1;
                end
            end
            S_REPL: begin
                if (!i_status.repl_done) begin
                    o_cmd.emit_repl = i_status.gen_ok;
                end else begin
                    o_cmd.clear_count = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!i_status.count_zero) begin
                    o_cmd.emit_held = i_status.gen_ok;
                end
            end
            S_DONE: begin
                if (i_status.pend_v) begin
                    o_cmd.final_push = i_status.out_free;
                end else if (i_status.eos) begin
                    o_cmd.bare_push = i_status.out_free;
                end
            end
            default: begin
            end
        endcase
    end

    `SFR_ASSERT_IMPL(a_idle_no_pending, r_state == S_IDLE, !i_status.pend_v)
    `SFR_ASSERT_NEXT(a_accept_to_scan, o_cmd.accept, r_state == S_SCAN)

endmodule

// ===== sv/stream_find_replace_top.sv =====
// Streaming find-and-replace, one text byte per item.
// Input channel: i_valid / o_stall with i_in_byte and i_end_of_stream. An
// item is taken at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_out_byte, o_byte_valid,
// o_run_last and o_stream_end. Each input item yields zero or more result
// items; o_run_last flags the last one of a run, o_stream_end the last one
// of the text, and a run with no bytes at end of text is a bare marker with
// o_byte_valid low.
// Items are handled one at a time. An item that produces nothing passes
// through accept, prefix check and wrap-up; each emitted byte goes through
// the serial emit path, and an item also passes through a replacement step
// when it completes a match and a flush step when it ends the text. The
// last result of a run reaches the output register at wrap-up.
// A receiver stall freezes the output register; the emit path backs up
// through its one-byte holding stage and o_stall stays high meanwhile.
// Reset (synchronous, active low) empties the held prefix and both output
// stages and restores the registers to pattern length one, no replacement.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
module stream_find_replace_top #(
    parameter int MAX_PATTERN_BYTES     = 16,
    parameter int MAX_REPLACEMENT_BYTES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_end_of_stream,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_byte_valid,
    output logic                            o_run_last,
    output logic                            o_stream_end,
    input  logic                            i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sfr_pkg::*;

    // The registers carry at most sixteen bytes, so the held buffer and the
    // replacement counter never need to be deeper than that.
    localparam int HELD_DEPTH =
        (MAX_PATTERN_BYTES < REG_BYTES) ? MAX_PATTERN_BYTES : REG_BYTES;
    localparam int REPL_LIM =
        (MAX_REPLACEMENT_BYTES < REG_BYTES) ? MAX_REPLACEMENT_BYTES : REG_BYTES;

    t_cmd    cmd;
    t_status status;

    sfr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    sfr_datapath #(
        .HELD_DEPTH (HELD_DEPTH),
        .REPL_LIM   (REPL_LIM)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_stall         (i_stall),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_run_last      (o_run_last),
        .o_stream_end    (o_stream_end)
    );

endmodule
